/* hw/rtl/drda_hcc_pkg.sv */
// shared types and constants for the drda header chain checker
`default_nettype none

package drda_hcc_pkg;

    localparam int unsigned HdrBytes  = 10;
    localparam int unsigned WinBytes  = HdrBytes - 1;
    localparam logic [7:0]  HdrMagic  = 8'hD0;
    localparam logic [16:0] LenOffset = 17'd6;
    localparam logic [15:0] PosMax    = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [15:0] payload_length;
        logic        is_tcp;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic        ok;
        logic [15:0] len;
    } t_hdr_status;

endpackage

`default_nettype wire

/* hw/rtl/drda_hcc_if.sv */
// valid/ready channel interfaces for the payload input and the verdict output
`default_nettype none

interface drda_hcc_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic [15:0] payload_length;
    logic        is_tcp;
    logic        last;

    modport source (output valid, output payload_byte, output payload_length,
                    output is_tcp, output last, input ready);
    modport sink   (input valid, input payload_byte, input payload_length,
                    input is_tcp, input last, output ready);
endinterface

interface drda_hcc_out_if;
    logic valid;
    logic ready;
    logic verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

`default_nettype wire

/* hw/rtl/drda_hcc_window.sv */
// byte window shift register and header field decode
`default_nettype none

module drda_hcc_window
    import drda_hcc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_shift,
    input  wire logic [7:0]  i_byte,
    output t_hdr_status      o_hdr
);

    // r_win[WinBytes-1] is the newest byte
    logic [7:0]  r_win [WinBytes];
    logic [15:0] len;
    logic [15:0] len2;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            for (int i = 0; i < int'(WinBytes) - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[WinBytes-1] <= i_byte;
        end
    end

    // header as seen once the incoming byte lands at its tenth place
    assign len  = {r_win[0], r_win[1]};
    assign len2 = {r_win[6], r_win[7]};

    assign o_hdr = '{ok:  (r_win[2] == HdrMagic) &&
                          ({1'b0, len} == ({1'b0, len2} + LenOffset)),
                     len: len};

endmodule

`default_nettype wire

/* hw/rtl/drda_hcc_chain.sv */
// chain tracking state, verdict logic and result register
`default_nettype none

module drda_hcc_chain
    import drda_hcc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_in_item    i_item,
    input  wire t_hdr_status i_hdr,
    input  wire logic        i_out_ready,
    output logic             o_go,
    output logic             o_out_valid,
    output logic             o_verdict
);

    logic [15:0] r_pos;
    logic [17:0] r_nhs;
    logic [15:0] r_ffl;
    logic        r_failed;
    logic        r_tcp;
    logic        r_out_valid;
    logic        r_verdict;

    logic [15:0] n_pos;
    logic [17:0] n_nhs;
    logic [15:0] n_ffl;
    logic        n_failed;
    logic        n_tcp;
    logic        n_verdict;

    logic [18:0] nhs_p9;
    logic [18:0] nhs_p10;
    logic        at_first;
    logic        at_next;

    // non-last items never touch the result register
    assign o_go = i_valid && (!i_item.last || !r_out_valid || i_out_ready);

    assign nhs_p9   = {1'b0, r_nhs} + 19'(HdrBytes - 1);
    assign nhs_p10  = {1'b0, r_nhs} + 19'(HdrBytes);
    assign at_first = (r_pos == 16'(HdrBytes - 1));
    assign at_next  = (r_pos > 16'(HdrBytes - 1)) && ({3'b0, r_pos} == nhs_p9) &&
                      (nhs_p10 < {3'b0, i_item.payload_length});

    always_comb begin
        n_tcp    = (r_pos == 16'd0) ? i_item.is_tcp : r_tcp;
        n_failed = r_failed;
        n_ffl    = r_ffl;
        n_nhs    = r_nhs;
        if (!r_failed) begin
            if (at_first) begin
                if (!i_hdr.ok) begin
                    n_failed = 1'b1;
                end else begin
                    n_ffl = i_hdr.len;
                    n_nhs = {2'b0, i_hdr.len};
                end
            end else if (at_next) begin
                if (!i_hdr.ok) begin
                    n_failed = 1'b1;
                end else begin
                    n_nhs = r_nhs + {2'b0, i_hdr.len};
                end
            end
        end
        n_pos = (r_pos != PosMax) ? r_pos + 16'd1 : r_pos;
        n_verdict = n_tcp && (i_item.payload_length >= 16'(HdrBytes)) && !n_failed &&
                    (({1'b0, r_pos} + 17'd1) == {1'b0, i_item.payload_length}) &&
                    ((i_item.payload_length <= n_ffl) ||
                     (n_nhs == {2'b0, i_item.payload_length}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_nhs       <= '0;
            r_ffl       <= '0;
            r_failed    <= 1'b0;
            r_tcp       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_go) begin
                if (i_item.last) begin
                    r_pos    <= '0;
                    r_nhs    <= '0;
                    r_ffl    <= '0;
                    r_failed <= 1'b0;
                    r_tcp    <= 1'b0;
                end else begin
                    r_pos    <= n_pos;
                    r_nhs    <= n_nhs;
                    r_ffl    <= n_ffl;
                    r_failed <= n_failed;
                    r_tcp    <= n_tcp;
                end
            end
            if (o_go && i_item.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_go && i_item.last) begin
            r_verdict <= n_verdict;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;

    // per-packet state is clean after the closing transfer
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_go && i_item.last |=> r_pos == 16'd0 && !r_failed && r_nhs == 18'd0)
        else $error("packet state not cleared after last item");

    // a result only appears because a last item was processed
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_go && i_item.last))
        else $error("result raised without a last item");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |-> !(o_go && i_item.last))
        else $error("pending result overwritten");

    // position counter saturates
    a_pos_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_go && !i_item.last && r_pos == PosMax |=> r_pos == PosMax)
        else $error("position counter wrapped");

    // a bad first header marks the chain as failed
    a_first_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_go && !i_item.last && at_first && !i_hdr.ok |=> r_failed)
        else $error("failed first header not recorded");

endmodule

`default_nettype wire

/* hw/rtl/drda_header_chain_check.sv */
// a last byte passes the input register, then its verdict is held in the verdict register
// throughput: one payload byte per cycle while input ready is high, one verdict per packet on its last byte
// the input register and the verdict register are the two stages; input ready
// drops only when a last byte waits behind an untaken verdict
// reset: synchronous active-low clears the stage valids and the chain state
// top level of the drda header chain checker
`default_nettype none

module drda_header_chain_check
    import drda_hcc_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    drda_hcc_in_if.sink         i_in,
    drda_hcc_out_if.source      o_out
);

    logic        r_s1_valid;
    t_in_item    r_s1_item;
    logic        s1_go;
    logic        in_ready;
    t_hdr_status hdr;

    assign in_ready   = !r_s1_valid || s1_go;
    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_s1_item.payload_byte   <= i_in.payload_byte;
            r_s1_item.payload_length <= i_in.payload_length;
            r_s1_item.is_tcp         <= i_in.is_tcp;
            r_s1_item.last           <= i_in.last;
        end
    end

    drda_hcc_window u_window (
        .i_clk   (i_clk),
        .i_shift (s1_go),
        .i_byte  (r_s1_item.payload_byte),
        .o_hdr   (hdr)
    );

    drda_hcc_chain u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s1_valid),
        .i_item      (r_s1_item),
        .i_hdr       (hdr),
        .i_out_ready (o_out.ready),
        .o_go        (s1_go),
        .o_out_valid (o_out.valid),
        .o_verdict   (o_out.verdict)
    );

endmodule

`default_nettype wire
